// File: rtl/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types, constants and helper functions for the brightness palette
// update block: slot mapping, register indexes and the stage records.
// ----------------------------------------------------------------------------
package bpu_pkg;

	localparam int SLOT_W  = 12;
	localparam int WORD_W  = 16;
	localparam int CHAN_W  = 8;
	localparam int NIB_W   = 4;
	localparam int SLOTS   = 1 << SLOT_W;

	// scaled product width: (nib*17) * (brightness+15) <= 255*30
	localparam int PROD_W  = 13;

	localparam logic [SLOT_W-1:0] IDX_LIMIT = 12'hC00;
	localparam logic [SLOT_W-1:0] OBJ_LIMIT = 12'h200;
	localparam logic [SLOT_W-1:0] DEST_XOR  = 12'h00F;
	localparam logic [1:0]        OBJ_BUF_TOP = 2'b11;

	// brightness offset and divisor of the scale factor
	localparam logic [4:0] BRIGHT_OFS = 5'd15;
	localparam int         SCALE_DIV  = 30;
	// floor(x*RECIP_MUL >> RECIP_SHIFT) is x/30 or x/30 + 1 for x <= 7650
	localparam int         RECIP_MUL   = 2185;
	localparam int         RECIP_SHIFT = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_GEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_OBJ    = 1'd1;

	// lookup request from the front end into the shadow stage
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] word;
		logic              force_wr;
	} bpu_req_t;

	// decision handed from the shadow stage to the scaler
	typedef struct packed {
		logic              emit;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] word;
	} bpu_upd_t;

	// map an incoming entry index to its converted palette slot
	function automatic logic [SLOT_W-1:0] map_slot(
		input logic [SLOT_W-1:0] idx,
		input logic              second_gen,
		input logic              lag_obj,
		input logic              frame_odd,
		input logic              force_wr
	);
		logic [SLOT_W-1:0] slot;
		if (second_gen && lag_obj && (idx < OBJ_LIMIT)) begin
			// forced writes hit the current-parity buffer, others the opposite one
			slot = {OBJ_BUF_TOP, frame_odd ^ ~force_wr, idx[8:0]};
		end else begin
			slot = idx;
		end
		return slot;
	endfunction

	// widen a nibble to 8 bits and multiply by (brightness + 15)
	function automatic logic [PROD_W-1:0] chan_prod(
		input logic [NIB_W-1:0] nib,
		input logic [NIB_W-1:0] bright
	);
		logic [PROD_W-1:0] wide;
		logic [PROD_W-1:0] factor;
		wide   = PROD_W'({nib, nib});
		factor = PROD_W'(5'(bright) + BRIGHT_OFS);
		return wide * factor;
	endfunction

	// divide a product by 30 through a reciprocal multiply and one correction
	function automatic logic [CHAN_W-1:0] div_scale(input logic [PROD_W-1:0] p);
		logic [25:0] m;
		logic [8:0]  est;
		logic [13:0] back;
		m    = 26'(p) * 26'(RECIP_MUL);
		est  = m[RECIP_SHIFT+8:RECIP_SHIFT];
		back = 14'(est) * 14'(SCALE_DIV);
		if (back > 14'(p)) begin
			est = est - 9'd1;
		end
		return est[CHAN_W-1:0];
	endfunction

endpackage

// File: rtl/bpu_if.sv
// ----------------------------------------------------------------------------
// bpu_if
// Valid/ready channels of the brightness palette update block: incoming
// palette entries and outgoing converted colors.
// ----------------------------------------------------------------------------
interface bpu_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] entry_index;
	logic [15:0] color_word;
	logic        frame_odd;
	logic        force_write;

	modport source (output valid, entry_index, color_word, frame_odd, force_write,
		input ready);
	modport sink (input valid, entry_index, color_word, frame_odd, force_write,
		output ready);
endinterface

interface bpu_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] dest_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	modport source (output valid, dest_index, red, green, blue, input ready);
	modport sink (input valid, dest_index, red, green, blue, output ready);
endinterface

// File: rtl/brightness_palette_update.sv
// Path: stage 1 register, then stage 2 products, then the stage 3 output register.
// Throughput: one entry per cycle unless the output stalls; the shadow memory read and
//   write ports each serve one access a cycle, with the last write forwarded to the
//   next read. Reset: registers clear at once; then a sweep zeroes the shadow memory,
//   and pal_in.ready stays low until it ends. Config writes are taken.
// ----------------------------------------------------------------------------
// brightness_palette_update
// Top level: configuration registers, slot mapping and input handshake,
// around the shadow memory stage and the brightness scaler.
// ----------------------------------------------------------------------------
module brightness_palette_update
	import bpu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_wdata,
	bpu_in_if.sink               pal_in,
	bpu_out_if.source            pal_out
);

	logic     second_gen_q;
	logic     lag_obj_q;
	logic     busy;
	logic     s1_valid;
	logic     s1_adv;
	logic     up_ready;
	logic     in_range;
	logic     take;
	bpu_req_t req;
	bpu_upd_t upd;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_gen_q <= 1'b0;
			lag_obj_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECOND_GEN: second_gen_q <= cfg_wdata;
				REG_LAG_OBJ:    lag_obj_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// accept after the sweep if stage 1 is free or draining; drop out-of-range entries
	assign pal_in.ready = !busy && (!s1_valid || (s1_adv && up_ready) || up_ready);
	assign in_range     = pal_in.entry_index < IDX_LIMIT;
	assign take         = pal_in.valid && pal_in.ready && in_range;

	always_comb begin
		req.slot     = map_slot(pal_in.entry_index, second_gen_q, lag_obj_q,
			pal_in.frame_odd, pal_in.force_write);
		req.word     = pal_in.color_word;
		req.force_wr = pal_in.force_write;
	end

	bpu_shadow u_shadow (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.req        (req),
		.down_ready (up_ready),
		.busy       (busy),
		.s1_valid   (s1_valid),
		.s1_adv     (s1_adv),
		.upd        (upd)
	);

	bpu_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_adv   (s1_adv),
		.upd      (upd),
		.up_ready (up_ready),
		.out_ch   (pal_out)
	);

endmodule

// File: rtl/bpu_shadow.sv
// ----------------------------------------------------------------------------
// bpu_shadow
// Shadow palette memory with read-compare-write stage. Clears the memory
// after reset, forwards the last write to cover the read/write overlap.
// ----------------------------------------------------------------------------
module bpu_shadow
	import bpu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  bpu_req_t req,
	input  logic     down_ready,
	output logic     busy,
	output logic     s1_valid,
	output logic     s1_adv,
	output bpu_upd_t upd
);

	logic [WORD_W-1:0] mem [SLOTS];
	logic [WORD_W-1:0] rdata_q;

	logic              clr_busy_q;
	logic [SLOT_W-1:0] clr_addr_q;

	logic              s1_valid_q;
	logic [SLOT_W-1:0] slot_s1;
	logic [WORD_W-1:0] word_s1;
	logic              force_s1;

	logic              fwd_valid_q;
	logic [SLOT_W-1:0] fwd_slot_q;
	logic [WORD_W-1:0] fwd_word_q;

	logic [WORD_W-1:0] old_word;
	logic              emit;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// sweep the memory to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + SLOT_W'(1);
			if (clr_addr_q == SLOT_W'(SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pick the freshest copy of the stored word
	always_comb begin
		old_word = rdata_q;
		if (fwd_valid_q && (fwd_slot_q == slot_s1)) begin
			old_word = fwd_word_q;
		end
	end

	assign emit   = force_s1 || (old_word != word_s1);
	assign s1_adv = s1_valid_q && down_ready;

	// write port: clearing sweep or update
	always_comb begin
		wr_en   = clr_busy_q || (s1_adv && emit);
		wr_addr = clr_busy_q ? clr_addr_q : slot_s1;
		wr_data = clr_busy_q ? '0 : word_s1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read on accept, hold while the stage stalls
	always_ff @(posedge clk) begin
		if (take) begin
			rdata_q <= mem[req.slot];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_s1  <= req.slot;
			word_s1  <= req.word;
			force_s1 <= req.force_wr;
		end
	end

	// remember the last update for the overlapping read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			fwd_slot_q <= slot_s1;
			fwd_word_q <= word_s1;
		end
	end

	assign busy     = clr_busy_q;
	assign s1_valid = s1_valid_q;
	assign upd      = '{emit: emit, slot: slot_s1, word: word_s1};

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !clr_busy_q)
		else $error("item taken during clearing sweep");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(slot_s1) && $stable(rdata_q)))
		else $error("stage 1 lost its item while stalled");

	a_fwd_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && emit) |=> (fwd_valid_q && fwd_slot_q == $past(slot_s1)))
		else $error("forward register missed an update");

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!s1_valid_q || s1_adv))
		else $error("item taken into an occupied stage");
`endif

endmodule

// File: rtl/bpu_scale.sv
// ----------------------------------------------------------------------------
// bpu_scale
// Brightness scaler: multiplies each widened channel by (brightness+15),
// divides by 30 and holds the result in the output register.
// ----------------------------------------------------------------------------
module bpu_scale
	import bpu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s1_adv,
	input  bpu_upd_t upd,
	output logic     up_ready,
	bpu_out_if.source out_ch
);

	logic              s2_valid_q;
	logic [SLOT_W-1:0] slot_s2;
	logic [PROD_W-1:0] pr_s2;
	logic [PROD_W-1:0] pg_s2;
	logic [PROD_W-1:0] pb_s2;

	logic              s3_valid_q;
	logic [SLOT_W-1:0] dest_s3;
	logic [CHAN_W-1:0] red_s3;
	logic [CHAN_W-1:0] green_s3;
	logic [CHAN_W-1:0] blue_s3;

	logic s3_free;
	logic s2_adv;
	logic [NIB_W-1:0] bright;

	assign s3_free  = !s3_valid_q || out_ch.ready;
	assign s2_adv   = s2_valid_q && s3_free;
	assign up_ready = !s2_valid_q || s3_free;
	assign bright   = upd.word[15:12];

	// stage 2: channel products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= upd.emit;
		end else if (s2_adv) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			slot_s2 <= upd.slot ^ DEST_XOR;
			pr_s2   <= chan_prod(upd.word[11:8], bright);
			pg_s2   <= chan_prod(upd.word[7:4], bright);
			pb_s2   <= chan_prod(upd.word[3:0], bright);
		end
	end

	// stage 3: divide and hold for the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s2_adv) begin
			s3_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			s3_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			dest_s3  <= slot_s2;
			red_s3   <= div_scale(pr_s2);
			green_s3 <= div_scale(pg_s2);
			blue_s3  <= div_scale(pb_s2);
		end
	end

	assign out_ch.valid      = s3_valid_q;
	assign out_ch.dest_index = dest_s3;
	assign out_ch.red        = red_s3;
	assign out_ch.green      = green_s3;
	assign out_ch.blue       = blue_s3;

endmodule

// File: bench/tb_brightness_palette_update.sv
// ----------------------------------------------------------------------------
// tb_brightness_palette_update
// Self-checking bench for the palette update block. A queue of palette
// entries feeds a driver with random gaps. A software copy of the shadow
// palette and registers predicts each converted color. A monitor with random
// and long stalls compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_brightness_palette_update;
	import bpu_pkg::*;

	localparam int          CYCLE_LIMIT   = 1000000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          LONG_HOLD     = 400;
	localparam int          PHASE_ITEMS   = 220;
	localparam int          PHASES        = 8;
	localparam logic [11:0] OBJ_BANK_BASE = 12'hC00;

	typedef struct {
		bit [SLOT_W-1:0] idx;
		bit [WORD_W-1:0] word;
		bit              odd;
		bit              force_wr;
	} pal_entry_t;

	typedef struct {
		bit [SLOT_W-1:0] dest;
		bit [CHAN_W-1:0] red;
		bit [CHAN_W-1:0] green;
		bit [CHAN_W-1:0] blue;
	} pal_color_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_wdata;

	bpu_in_if  pal_in_bus();
	bpu_out_if pal_out_bus();

	brightness_palette_update uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pal_in   (pal_in_bus),
		.pal_out  (pal_out_bus)
	);

	// shadow palette and register copies of the prediction
	logic [WORD_W-1:0] shadow_words [0:SLOTS-1];
	bit                gen2_mode;
	bit                lag_objects;

	pal_entry_t pending_entries[$];
	pal_color_t owed_colors[$];

	// driver state
	pal_entry_t offer;
	bit         offer_busy;
	int         send_gap;
	bit         send_calm;

	// monitor state
	int stall_left;
	bit recv_calm;
	int long_holds_asked;
	int long_holds_done;

	int fail_count;
	int cycle_count;

	bit phase_gen [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
	bit phase_lag [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	// widen a nibble to 8 bits and scale by (brightness + 15) / 30
	function automatic bit [CHAN_W-1:0] scale_nibble(input bit [3:0] nib,
		input bit [3:0] bright);
		int wide;
		wide = int'(nib) * 17;
		return CHAN_W'((wide * (int'(bright) + int'(BRIGHT_OFS))) / SCALE_DIV);
	endfunction

	// map the entry, update the shadow copy and owe a color if it changed or is forced
	function automatic void update_palette(input pal_entry_t e);
		bit [SLOT_W-1:0] slot;
		bit [SLOT_W-1:0] bank;
		pal_color_t      c;
		if (e.idx >= IDX_LIMIT) return;
		if (gen2_mode && lag_objects && e.idx < OBJ_LIMIT) begin
			bank = OBJ_BANK_BASE | (SLOT_W'(e.odd) << 9);
			if (!e.force_wr) bank = bank ^ OBJ_LIMIT;
			slot = bank + e.idx;
		end else begin
			slot = e.idx;
		end
		if (!e.force_wr && shadow_words[slot] == e.word) return;
		shadow_words[slot] = e.word;
		c.dest  = slot ^ DEST_XOR;
		c.red   = scale_nibble(e.word[11:8], e.word[15:12]);
		c.green = scale_nibble(e.word[7:4], e.word[15:12]);
		c.blue  = scale_nibble(e.word[3:0], e.word[15:12]);
		owed_colors.push_back(c);
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_entry(input bit [11:0] idx, input bit [15:0] word,
		input bit odd, input bit force_wr);
		pal_entry_t e;
		e.idx      = idx;
		e.word     = word;
		e.odd      = odd;
		e.force_wr = force_wr;
		pending_entries.push_back(e);
	endfunction

	// spread entries over all regions; revisit a few slots with few words
	function automatic pal_entry_t random_entry();
		pal_entry_t e;
		int         r;
		bit [11:0]  hot_base [4] = '{12'h000, 12'h1F8, 12'h400, 12'hBF8};
		bit [15:0]  hot_word [4] = '{16'h0000, 16'hFFFF, 16'h8A5C, 16'h0123};
		r          = $urandom_range(0, 99);
		e.word     = WORD_W'($urandom);
		e.odd      = 1'($urandom_range(0, 1));
		e.force_wr = ($urandom_range(0, 3) == 0);
		if (r < 30) begin
			e.idx  = hot_base[$urandom_range(0, 3)] + 12'($urandom_range(0, 7));
			e.word = hot_word[$urandom_range(0, 3)];
		end else if (r < 50) begin
			e.idx = 12'($urandom_range(0, 12'h1FF));
		end else if (r < 65) begin
			e.idx = 12'($urandom_range(12'h200, 12'h7FF));
		end else if (r < 80) begin
			e.idx = 12'($urandom_range(12'h800, 12'hBFF));
		end else if (r < 85) begin
			e.idx = 12'($urandom_range(12'hC00, 12'hFFF));
		end else begin
			e.idx = SLOT_W'($urandom);
		end
		return e;
	endfunction

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input bit val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SECOND_GEN) gen2_mode = val;
		else lag_objects = val;
	endtask

	// wait until every entry is taken and every owed color has arrived
	task automatic drain_and_settle();
		while (pending_entries.size() != 0 || offer_busy || owed_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// driver: offer queued entries with random gaps, predict on each beat
	always @(posedge clk) begin
		if (!arst_n) begin
			pal_in_bus.valid <= 1'b0;
		end else begin
			if (offer_busy && pal_in_bus.ready) begin
				update_palette(offer);
				offer_busy = 1'b0;
				send_gap   = send_calm ? 0 : pick_gap();
			end
			if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
			if (!offer_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_entries.size() != 0) begin
					offer      = pending_entries.pop_front();
					offer_busy = 1'b1;
				end
			end
			pal_in_bus.valid       <= offer_busy;
			pal_in_bus.entry_index <= offer.idx;
			pal_in_bus.color_word  <= offer.word;
			pal_in_bus.frame_odd   <= offer.odd;
			pal_in_bus.force_write <= offer.force_wr;
		end
	end

	// monitor: check each result beat, stall at random and on request
	always @(posedge clk) begin
		pal_color_t want;
		if (!arst_n) begin
			pal_out_bus.ready <= 1'b0;
		end else begin
			if (pal_out_bus.valid && pal_out_bus.ready) begin
				if (owed_colors.size() == 0) begin
					$error("unexpected color beat: dest_index %0h", pal_out_bus.dest_index);
					fail_count++;
				end else begin
					want = owed_colors.pop_front();
					if (pal_out_bus.dest_index !== want.dest) begin
						$error("dest_index: expected %0h actual %0h",
							want.dest, pal_out_bus.dest_index);
						fail_count++;
					end
					if (pal_out_bus.red !== want.red) begin
						$error("red: expected %0d actual %0d", want.red, pal_out_bus.red);
						fail_count++;
					end
					if (pal_out_bus.green !== want.green) begin
						$error("green: expected %0d actual %0d", want.green, pal_out_bus.green);
						fail_count++;
					end
					if (pal_out_bus.blue !== want.blue) begin
						$error("blue: expected %0d actual %0d", want.blue, pal_out_bus.blue);
						fail_count++;
					end
				end
				stall_left = recv_calm ? 0 : pick_gap();
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!recv_calm && $urandom_range(0, 15) == 0) begin
				stall_left = pick_gap();
			end
			if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
			// hold off long enough for the block to back up into its input
			if (stall_left == 0 && long_holds_done != long_holds_asked) begin
				long_holds_done++;
				stall_left = LONG_HOLD;
			end
			pal_out_bus.ready <= (stall_left == 0);
		end
	end

	initial begin
		pal_entry_t e;
		int         live;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = REG_SECOND_GEN;
		cfg_wdata              = 1'b0;
		pal_in_bus.valid       = 1'b0;
		pal_in_bus.entry_index = '0;
		pal_in_bus.color_word  = '0;
		pal_in_bus.frame_odd   = 1'b0;
		pal_in_bus.force_write = 1'b0;
		pal_out_bus.ready      = 1'b0;
		foreach (shadow_words[i]) shadow_words[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// first-generation layout: region edges, unchanged and ignored entries
		set_register(REG_SECOND_GEN, 1'b0);
		set_register(REG_LAG_OBJ, 1'b0);
		queue_entry(12'h000, 16'h0000, 1'b0, 1'b0);
		queue_entry(12'h000, 16'h0000, 1'b0, 1'b1);
		queue_entry(12'h000, 16'hFFFF, 1'b0, 1'b0);
		queue_entry(12'h1FF, 16'h0FFF, 1'b0, 1'b0);
		queue_entry(12'h200, 16'hF000, 1'b1, 1'b0);
		queue_entry(12'h7FF, 16'h8421, 1'b0, 1'b0);
		queue_entry(12'h800, 16'hFFFF, 1'b0, 1'b1);
		queue_entry(12'hBFF, 16'h7ABC, 1'b1, 1'b0);
		queue_entry(12'hC00, 16'h1234, 1'b0, 1'b1);
		queue_entry(12'hFFF, 16'hFFFF, 1'b1, 1'b1);
		queue_entry(12'h100, 16'h5A5A, 1'b1, 1'b0);
		drain_and_settle();

		// lagged objects: both buffers, both parities, forced and normal
		set_register(REG_SECOND_GEN, 1'b1);
		set_register(REG_LAG_OBJ, 1'b1);
		queue_entry(12'h000, 16'h1111, 1'b0, 1'b0);
		queue_entry(12'h000, 16'h1111, 1'b0, 1'b0);
		queue_entry(12'h000, 16'h1111, 1'b0, 1'b1);
		queue_entry(12'h1FF, 16'hFFFF, 1'b1, 1'b0);
		queue_entry(12'h1FF, 16'hFFFF, 1'b1, 1'b1);
		queue_entry(12'h0AB, 16'h3C96, 1'b1, 1'b0);
		queue_entry(12'h200, 16'hFFFF, 1'b1, 1'b0);
		queue_entry(12'h200, 16'hFFFF, 1'b1, 1'b0);
		queue_entry(12'h800, 16'h0001, 1'b0, 1'b0);
		queue_entry(12'hC00, 16'hBEEF, 1'b1, 1'b0);
		drain_and_settle();

		// second generation without lag: objects map directly
		set_register(REG_LAG_OBJ, 1'b0);
		queue_entry(12'h000, 16'h2222, 1'b1, 1'b0);
		queue_entry(12'h1FF, 16'hE0F0, 1'b0, 1'b1);
		drain_and_settle();

		// random phases over every register setting
		for (int p = 0; p < PHASES; p++) begin
			set_register(REG_SECOND_GEN, phase_gen[p]);
			set_register(REG_LAG_OBJ, phase_lag[p]);
			if (p == 0 || p == 4) long_holds_asked++;
			live = 0;
			while (live < PHASE_ITEMS) begin
				e = random_entry();
				pending_entries.push_back(e);
				if (e.idx < IDX_LIMIT) live++;
			end
			drain_and_settle();
		end

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/bpu_pkg.sv
rtl/bpu_if.sv
rtl/bpu_shadow.sv
rtl/bpu_scale.sv
rtl/brightness_palette_update.sv
bench/tb_brightness_palette_update.sv
